[hw/rtl/sequential_list_engine_defines.svh]
// Assertion macros for the list engine RTL.
`ifndef SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define SLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/sle_pkg.sv]
// Shared types and codes for the list engine.
`timescale 1ns / 1ps
package sle_pkg;

  localparam int VALUE_W    = 32;
  localparam int SCAN_GROUP = 8;

  typedef enum logic [2:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_INSERT     = 3'd4,
    REQ_ERASE      = 3'd5,
    REQ_FIND       = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_FIND   = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

[hw/rtl/sequential_list_engine.sv]
// Top level of the list engine: request decode, cell chain, scanner, result register.
`timescale 1ns / 1ps
`include "sequential_list_engine_defines.svh"
// Dense ordered list of signed 32-bit values held in a chain of CAPACITY
// cells, one entry per cell. Each accepted request word gives exactly one
// result word. Push, pop, insert and erase finish in the cycle of accept:
// every cell loads its new value from the request, its left neighbor
// (shift up) or its right neighbor (shift down) at once, and the result
// word is registered at the same edge. A find compares all cells in the
// accept cycle and registers a match flag per cell; the scanner then walks
// the flags eight cells per cycle from the lowest group upward, ending
// at the first group holding a match or at the last group.
// The slave side takes a new word outside reset when no find is in flight
// and the result register is empty or being drained in the same cycle.
// Entries come up undefined after reset; only the occupancy counter, state and
// result-valid are cleared; only entries below the count are ever compared or reported.
module sequential_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [6:0] position, [38:7] value, [39] zero
  input  logic [2:0]  s_tuser,   // [2:0] req_type
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [5:0] found_index, [12:6] count, [15:13] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (CW > 7) ? CW : 7;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                        state;
  logic [CW-1:0]                 cnt;
  logic [CW-1:0]                 cnt_next;
  logic                          accept;
  sle_pkg::req_t                 req;
  logic [6:0]                    position;
  logic [sle_pkg::VALUE_W-1:0]   value_in;
  logic [PW-1:0]                 pos_w;
  logic [PW-1:0]                 cnt_w;
  logic                          full;
  logic                          empty;
  logic                          is_find;
  sle_pkg::cell_ctrl_t           ctrl;
  logic [CW-1:0]                 cell_pos;
  sle_pkg::status_t              res_status;
  logic [sle_pkg::VALUE_W-1:0]   entry_q [CAPACITY];
  logic [CAPACITY-1:0]           match_q;
  logic                          scan_done;
  logic                          scan_hit;
  logic [IW-1:0]                 scan_index;
  sle_pkg::status_t              out_status;
  logic [5:0]                    out_found;
  logic [6:0]                    out_count;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !rst && (state == S_IDLE) && (!m_tvalid || m_tready);
  assign req      = sle_pkg::req_t'(s_tuser[2:0]);
  assign position = s_tdata[6:0];
  assign value_in = s_tdata[38:7];
  assign pos_w    = PW'(position);
  assign cnt_w    = PW'(cnt);
  assign full     = (cnt == CW'(CAPACITY));
  assign empty    = (cnt == '0);

  // Decode the request into one chain command and the new occupancy.
  // Push back and push front are inserts at the tail and the head; pop
  // front is a remove at the head; pop back only drops the count.
  always_comb begin
    ctrl.op    = sle_pkg::CELL_HOLD;
    ctrl.value = value_in;
    cell_pos   = '0;
    cnt_next   = cnt;
    res_status = sle_pkg::ST_OK;
    is_find    = 1'b0;
    if (accept) begin
      case (req)
        sle_pkg::REQ_PUSH_BACK: begin
          if (full) begin
            res_status = sle_pkg::ST_FULL;
          end else begin
            ctrl.op  = sle_pkg::CELL_INSERT;
            cell_pos = cnt;
            cnt_next = cnt + CW'(1);
          end
        end
        sle_pkg::REQ_PUSH_FRONT: begin
          if (full) begin
            res_status = sle_pkg::ST_FULL;
          end else begin
            ctrl.op  = sle_pkg::CELL_INSERT;
            cnt_next = cnt + CW'(1);
          end
        end
        sle_pkg::REQ_POP_BACK: begin
          if (empty) begin
            res_status = sle_pkg::ST_BAD;
          end else begin
            cnt_next = cnt - CW'(1);
          end
        end
        sle_pkg::REQ_POP_FRONT: begin
          if (empty) begin
            res_status = sle_pkg::ST_BAD;
          end else begin
            ctrl.op  = sle_pkg::CELL_REMOVE;
            cnt_next = cnt - CW'(1);
          end
        end
        sle_pkg::REQ_INSERT: begin
          // Position check ranks ahead of the full check.
          if (pos_w > cnt_w) begin
            res_status = sle_pkg::ST_BAD;
          end else if (full) begin
            res_status = sle_pkg::ST_FULL;
          end else begin
            ctrl.op  = sle_pkg::CELL_INSERT;
            cell_pos = CW'(pos_w);
            cnt_next = cnt + CW'(1);
          end
        end
        sle_pkg::REQ_ERASE: begin
          if (pos_w >= cnt_w) begin
            res_status = sle_pkg::ST_BAD;
          end else begin
            ctrl.op  = sle_pkg::CELL_REMOVE;
            cell_pos = CW'(pos_w);
            cnt_next = cnt - CW'(1);
          end
        end
        sle_pkg::REQ_FIND: begin
          ctrl.op = sle_pkg::CELL_FIND;
          is_find = 1'b1;
        end
        default: begin
          res_status = sle_pkg::ST_BAD;
        end
      endcase
    end
  end

  // Cell chain: each cell sees its two neighbors. The head has no left
  // neighbor (it never shifts up); the tail feeds itself on a shift down.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [sle_pkg::VALUE_W-1:0] left_entry;
    logic [sle_pkg::VALUE_W-1:0] right_entry;
    if (g == 0) begin : g_head
      assign left_entry = ctrl.value;
    end else begin : g_mid_l
      assign left_entry = entry_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_entry = entry_q[g];
    end else begin : g_mid_r
      assign right_entry = entry_q[g+1];
    end
    sle_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .pos         (cell_pos),
      .count       (cnt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry_q[g]),
      .match       (match_q[g])
    );
  end

  // Walk the match flags registered in the accept cycle of a find.
  sle_scan #(
    .DEPTH (CAPACITY)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (accept && is_find),
    .match (match_q),
    .done  (scan_done),
    .hit   (scan_hit),
    .index (scan_index)
  );

  // Control: occupancy, find sequencing and result-valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      case (state)
        S_IDLE: begin
          if (accept && is_find) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if ((accept && !is_find) || scan_done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result word: loaded on a non-find accept or when the scan ends.
  always_ff @(posedge clk) begin
    if (accept && !is_find) begin
      out_status <= res_status;
      out_found  <= '0;
      out_count  <= 7'(cnt_next);
    end else if (scan_done) begin
      out_status <= scan_hit ? sle_pkg::ST_OK : sle_pkg::ST_MISS;
      out_found  <= scan_hit ? 6'(scan_index) : 6'd0;
      out_count  <= 7'(cnt);
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {3'b000, out_count, out_found};

  `SLE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= CW'(CAPACITY), "occupancy above capacity")
  `SLE_ASSERT_NOW(a_no_take_in_scan, state == S_SCAN, !s_tready, "word taken during find")
  `SLE_ASSERT_NOW(a_done_in_scan, scan_done, state == S_SCAN, "scan finished outside find")
  `SLE_ASSERT_NEXT(a_find_enters_scan, accept && is_find, state == S_SCAN, "find did not start scan")
  `SLE_ASSERT_NOW(a_no_result_in_scan, state == S_SCAN, !m_tvalid, "stale result during find")

endmodule

[hw/rtl/sle_cell.sv]
// One storage cell of the list chain: holds one entry and its match flag.
`timescale 1ns / 1ps
module sle_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                           clk,
  input  sle_pkg::cell_ctrl_t            ctrl,
  input  logic [CW-1:0]                  pos,
  input  logic [CW-1:0]                  count,
  input  logic [sle_pkg::VALUE_W-1:0]    left_entry,
  input  logic [sle_pkg::VALUE_W-1:0]    right_entry,
  output logic [sle_pkg::VALUE_W-1:0]    entry,
  output logic                           match
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  // Insert: take the new value at pos, take the left neighbor above it.
  // Remove: take the right neighbor from pos upward.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      sle_pkg::CELL_INSERT: begin
        if (MY_IDX == pos) begin
          entry <= ctrl.value;
        end else if (MY_IDX > pos) begin
          entry <= left_entry;
        end
      end
      sle_pkg::CELL_REMOVE: begin
        if (MY_IDX >= pos) begin
          entry <= right_entry;
        end
      end
      sle_pkg::CELL_FIND: begin
        match <= (entry == ctrl.value) && (MY_IDX < count);
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/sle_scan.sv]
// Lowest-index search over the registered match flags, one group per cycle.
`timescale 1ns / 1ps
module sle_scan #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DEPTH-1:0]           match,
  output logic                       done,
  output logic                       hit,
  output logic [$clog2(DEPTH)-1:0]   index
);

  localparam int NG   = (DEPTH + sle_pkg::SCAN_GROUP - 1) / sle_pkg::SCAN_GROUP;
  localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
  localparam int GSH  = $clog2(sle_pkg::SCAN_GROUP);
  localparam int IW   = $clog2(DEPTH);
  localparam int PADW = NG * sle_pkg::SCAN_GROUP;

  logic                           busy;
  logic [GW-1:0]                  grp;
  logic [PADW-1:0]                padded;
  logic [sle_pkg::SCAN_GROUP-1:0] grp_bits;
  logic [GSH-1:0]                 local_idx;

  assign padded   = PADW'(match);
  assign grp_bits = padded[grp * sle_pkg::SCAN_GROUP +: sle_pkg::SCAN_GROUP];

  always_comb begin
    local_idx = '0;
    for (int k = sle_pkg::SCAN_GROUP - 1; k >= 0; k--) begin
      if (grp_bits[k]) begin
        local_idx = GSH'(k);
      end
    end
  end

  assign hit   = |grp_bits;
  assign done  = busy && (hit || (grp == GW'(NG - 1)));
  assign index = IW'({grp, local_idx});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      grp  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      grp  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      grp <= grp + GW'(1);
    end
  end

endmodule
